// ===== design/bns_pkg.sv =====
`default_nettype none

package bns_pkg;

   // Sizing of the column and row space.
   localparam int MAX_CHANNELS = 8;
   localparam int MAX_ROWS     = 8;

   // Widths fixed by the beat fields and the per-column state.
   localparam int COL_W  = 3;
   localparam int ROW_W  = 3;
   localparam int POS_W  = 4;
   localparam int CFG_W  = 4;
   localparam int ADDR_W = $clog2(MAX_CHANNELS);
   localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);

   localparam logic [POS_W-1:0] ROW_NONE = {POS_W{1'b1}};

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_NUM_CHANNELS = 1'b0,
      CSR_NUM_ROWS     = 1'b1
   } csr_index_type;

   // Request function codes.
   typedef enum logic [0:0] {
      FUNC_PRESS = 1'b0,
      FUNC_BEAT  = 1'b1
   } func_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRESS,
      ST_BEAT
   } state_type;

   // One column's state as held in the column memory.
   typedef struct packed {
      logic             active;
      logic             moving_up;
      logic [POS_W-1:0] position;
      logic [POS_W-1:0] turn_row;
      logic             pending;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   localparam entry_type ENTRY_RESET = '{
      active:    1'b0,
      moving_up: 1'b0,
      position:  '0,
      turn_row:  ROW_NONE,
      pending:   1'b0
   };

endpackage

`default_nettype wire

// ===== design/bns_ram.sv =====
`default_nettype none

module bns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port that holds when not enabled.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/bouncing_note_sequencer_core.sv =====
`default_nettype none

// Bouncing note sequencer: each column keeps a ball that runs between the
// bottom row and a top row picked by a button press. A press beat (func 0)
// gives no result; a press on the column's top row stops the column, any
// other row arms it. A tick beat (func 1) gives one result beat per column
// in use (num_channels saturated at eight), in column order, with last set
// on the final one; the column memory is read one column ahead, and a stall
// on the result side holds the walk. One item is worked on at a time;
// req_stall is high until the previous item's column updates are all
// written back. Column state lives in an eight-entry memory with a
// registered read; per-entry valid flags, cleared by reset, make unwritten
// entries read as the reset state, so no clearing pass is needed.
// Configuration must be written only while the block is idle; the block
// itself does not enforce this.
module bouncing_note_sequencer_core
   import bns_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   // Configuration port.
   input  wire logic             csr_write,
   input  wire logic [0:0]       csr_index,
   input  wire logic [CFG_W-1:0] csr_wdata,
   // Request channel.
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             req_func,
   input  wire logic [COL_W-1:0] req_press_column,
   input  wire logic [ROW_W-1:0] req_press_row,
   // Result channel.
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [COL_W-1:0]      rsp_channel,
   output logic                  rsp_column_active,
   output logic [ROW_W-1:0]      rsp_ball_row,
   output logic [ROW_W-1:0]      rsp_top_row,
   output logic                  rsp_play_note,
   output logic                  rsp_last
);

   // Configuration registers.
   logic [CFG_W-1:0] num_channels_ff;
   logic [CFG_W-1:0] num_rows_ff;

   // Control state.
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [MAX_CHANNELS-1:0] valid_ff;
   logic              rd_valid_ff;

   // Result register.
   logic             rsp_valid_ff;
   logic [COL_W-1:0] rsp_channel_ff;
   logic             rsp_active_ff;
   logic [ROW_W-1:0] rsp_ball_ff;
   logic [ROW_W-1:0] rsp_top_ff;
   logic             rsp_play_ff;
   logic             rsp_last_ff;

   // Memory access.
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;
   logic [ENTRY_W-1:0] ram_rd_data;

   // Derived values.
   logic [CNT_W-1:0] cols;
   logic [POS_W-1:0] rows;
   logic [POS_W-1:0] bottom;
   entry_type        cur;
   entry_type        press_entry;
   entry_type        beat_entry;
   logic [POS_W-1:0] beat_pos;
   logic             col_last;
   logic             out_free;
   logic             load_out;
   logic             req_accept;

   bns_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_CHANNELS)
   ) u_column_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // Saturated column and row counts.
   always_comb begin
      if (num_channels_ff > CFG_W'(MAX_CHANNELS)) begin
         cols = CNT_W'(MAX_CHANNELS);
      end else begin
         cols = CNT_W'(num_channels_ff);
      end
      if (num_rows_ff == '0) begin
         rows = POS_W'(1);
      end else if (num_rows_ff > CFG_W'(MAX_ROWS)) begin
         rows = POS_W'(MAX_ROWS);
      end else begin
         rows = POS_W'(num_rows_ff);
      end
      bottom = rows - POS_W'(1);
   end

   // An entry that was never written reads as the reset state.
   assign cur = rd_valid_ff ? entry_type'(ram_rd_data) : ENTRY_RESET;

   // Update of a column on a press of the latched row.
   always_comb begin
      press_entry = cur;
      if (cur.turn_row == POS_W'(row_ff)) begin
         press_entry.active   = 1'b0;
         press_entry.turn_row = ROW_NONE;
      end else begin
         press_entry.turn_row  = POS_W'(row_ff);
         press_entry.active    = 1'b1;
         press_entry.moving_up = 1'b1;
         press_entry.pending   = 1'b1;
         press_entry.position  = rows;
      end
   end

   // Update of a column on a tick: bounce at the bottom and the top, then step.
   always_comb begin
      beat_entry = cur;
      beat_pos   = '0;
      if (cur.active) begin
         if (cur.position >= bottom) begin
            beat_entry.pending   = 1'b1;
            beat_entry.moving_up = 1'b1;
            beat_entry.position  = bottom;
         end
         if (beat_entry.position == cur.turn_row) begin
            beat_entry.moving_up = 1'b0;
         end
         beat_pos = beat_entry.position;
         if (beat_entry.moving_up) begin
            beat_entry.position = beat_pos - POS_W'(1);
         end else begin
            beat_entry.position = beat_pos + POS_W'(1);
         end
      end
   end

   assign col_last   = (CNT_W'(col_ff) + CNT_W'(1)) == cols;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid && !req_stall;

   // Sequencer: next state, memory access and result load.
   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      rd_en    = 1'b0;
      rd_addr  = col_ff;
      wr_en    = 1'b0;
      wr_addr  = col_ff;
      wr_data  = beat_entry;
      load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_func == FUNC_BEAT) begin
                  if (cols != '0) begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     col_in   = '0;
                     state_in = ST_BEAT;
                  end
               end else if ((CNT_W'(req_press_column) < cols)
                            && (POS_W'(req_press_row) < rows)) begin
                  rd_en    = 1'b1;
                  rd_addr  = ADDR_W'(req_press_column);
                  col_in   = ADDR_W'(req_press_column);
                  row_in   = req_press_row;
                  state_in = ST_PRESS;
               end
            end
         end
         ST_PRESS: begin
            wr_en    = 1'b1;
            wr_data  = press_entry;
            state_in = ST_IDLE;
         end
         ST_BEAT: begin
            if (out_free) begin
               wr_en           = 1'b1;
               wr_data.pending = 1'b0;
               load_out        = 1'b1;
               if (col_last) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in  = col_ff + ADDR_W'(1);
                  rd_en   = 1'b1;
                  rd_addr = col_ff + ADDR_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         num_channels_ff <= CFG_W'(MAX_CHANNELS);
         num_rows_ff     <= CFG_W'(MAX_ROWS);
         valid_ff        <= '0;
         rd_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            unique case (csr_index_type'(csr_index))
               CSR_NUM_CHANNELS: num_channels_ff <= csr_wdata;
               CSR_NUM_ROWS:     num_rows_ff     <= csr_wdata;
               default:          num_rows_ff     <= num_rows_ff;
            endcase
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers and result payload.
   always_ff @(posedge clock) begin
      col_ff <= col_in;
      row_ff <= row_in;
      if (load_out) begin
         rsp_channel_ff <= COL_W'(col_ff);
         rsp_active_ff  <= cur.active;
         rsp_ball_ff    <= beat_pos[ROW_W-1:0];
         rsp_top_ff     <= cur.active ? cur.turn_row[ROW_W-1:0] : '0;
         rsp_play_ff    <= beat_entry.pending;
         rsp_last_ff    <= col_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_channel       = rsp_channel_ff;
   assign rsp_column_active = rsp_active_ff;
   assign rsp_ball_row      = rsp_ball_ff;
   assign rsp_top_row       = rsp_top_ff;
   assign rsp_play_note     = rsp_play_ff;
   assign rsp_last          = rsp_last_ff;

   // A read and a write never meet on the same column.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("column memory read and write collide");

   // Results are loaded only while a tick walks the columns.
   a_load_in_beat: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (state_ff == ST_BEAT))
      else $error("result loaded outside a tick");

   // The final column's result ends the tick.
   a_last_ends_beat: assert property (@(posedge clock) disable iff (reset)
      (load_out && col_last) |=> (state_ff == ST_IDLE))
      else $error("tick did not end after its final column");

   // A press writes its column exactly once, in the cycle after its read.
   a_press_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRESS) |-> (wr_en && !rd_en && !load_out))
      else $error("press update not written back");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none

module tb_top;
   import bns_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 8;

   // One result beat as the block reports it.
   typedef struct packed {
      logic [COL_W-1:0] channel;
      logic             column_active;
      logic [ROW_W-1:0] ball_row;
      logic [ROW_W-1:0] top_row;
      logic             play_note;
      logic             last;
   } column_report_type;

   // Tracks the column state of the sequencer and the reports it owes.
   class column_report_board;
      logic [CFG_W-1:0] num_channels;
      logic [CFG_W-1:0] num_rows;
      logic             active     [MAX_CHANNELS];
      logic             moving_up  [MAX_CHANNELS];
      logic [POS_W-1:0] ball_pos   [MAX_CHANNELS];
      logic [POS_W-1:0] turn_row   [MAX_CHANNELS];
      logic             play_owed  [MAX_CHANNELS];
      column_report_type expected_reports[$];
      int               errors;
      int               checked;

      function new();
         num_channels = CFG_W'(MAX_CHANNELS);
         num_rows     = CFG_W'(MAX_ROWS);
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            active[i]    = 1'b0;
            moving_up[i] = 1'b0;
            ball_pos[i]  = '0;
            turn_row[i]  = ROW_NONE;
            play_owed[i] = 1'b0;
         end
         errors  = 0;
         checked = 0;
      endfunction

      function int cols_in_use();
         return (num_channels > MAX_CHANNELS) ? MAX_CHANNELS : int'(num_channels);
      endfunction

      function int rows_in_use();
         if (num_rows < 1) return 1;
         if (num_rows > MAX_ROWS) return MAX_ROWS;
         return int'(num_rows);
      endfunction

      function void write_reg(logic [0:0] index, logic [CFG_W-1:0] value);
         if (csr_index_type'(index) == CSR_NUM_CHANNELS) num_channels = value;
         else num_rows = value;
      endfunction

      // Advances the column state by one accepted request beat and queues
      // the column reports that a tick owes.
      function void apply_request(logic func, logic [COL_W-1:0] col,
                                  logic [ROW_W-1:0] row);
         int               cols;
         int               rows;
         int               i;
         logic [POS_W-1:0] bottom;
         logic [POS_W-1:0] pos;
         logic [POS_W-1:0] top;
         column_report_type rep;
         cols   = cols_in_use();
         rows   = rows_in_use();
         bottom = POS_W'(rows - 1);
         if (func_type'(func) == FUNC_PRESS) begin
            if (col >= cols || row >= rows) return;
            if (turn_row[col] == {1'b0, row}) begin
               active[col]   = 1'b0;
               turn_row[col] = ROW_NONE;
            end else begin
               turn_row[col]  = {1'b0, row};
               active[col]    = 1'b1;
               moving_up[col] = 1'b1;
               play_owed[col] = 1'b1;
               ball_pos[col]  = POS_W'(rows);
            end
            return;
         end
         for (i = 0; i < cols; i++) begin
            pos = '0;
            top = '0;
            if (active[i]) begin
               // The bottom row triggers the note and turns the ball upward.
               if (ball_pos[i] >= bottom) begin
                  play_owed[i] = 1'b1;
                  moving_up[i] = 1'b1;
                  ball_pos[i]  = bottom;
               end
               if (ball_pos[i] == turn_row[i]) moving_up[i] = 1'b0;
               pos = ball_pos[i];
               top = turn_row[i];
               ball_pos[i] = moving_up[i] ? pos - 1'b1 : pos + 1'b1;
            end
            rep.channel       = COL_W'(i);
            rep.column_active = active[i];
            rep.ball_row      = pos[ROW_W-1:0];
            rep.top_row       = top[ROW_W-1:0];
            rep.play_note     = play_owed[i];
            rep.last          = (i + 1 == cols);
            play_owed[i]      = 1'b0;
            expected_reports.push_back(rep);
         end
      endfunction

      function void compare_field(string name, int exp_val, int act_val);
         if (exp_val != act_val) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
         end
      endfunction

      function void check_report(column_report_type act);
         column_report_type exp_rep;
         if (expected_reports.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, expected none, got channel %0d",
                     $time, act.channel);
            return;
         end
         exp_rep = expected_reports.pop_front();
         checked++;
         compare_field("channel", exp_rep.channel, act.channel);
         compare_field("column_active", exp_rep.column_active, act.column_active);
         compare_field("ball_row", exp_rep.ball_row, act.ball_row);
         compare_field("top_row", exp_rep.top_row, act.top_row);
         compare_field("play_note", exp_rep.play_note, act.play_note);
         compare_field("last", exp_rep.last, act.last);
      endfunction

      function int outstanding();
         return expected_reports.size();
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_write = 1'b0;
   logic [0:0]       csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_func = 1'b0;
   logic [COL_W-1:0] req_press_column = '0;
   logic [ROW_W-1:0] req_press_row = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [COL_W-1:0] rsp_channel;
   logic             rsp_column_active;
   logic [ROW_W-1:0] rsp_ball_row;
   logic [ROW_W-1:0] rsp_top_row;
   logic             rsp_play_note;
   logic             rsp_last;

   column_report_board board = new();
   bit calm = 1'b0;
   int cycles = 0;
   int beats_sent = 0;
   int presses_sent = 0;
   int settings_used = 1;

   bouncing_note_sequencer_core dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_press_column  (req_press_column),
      .req_press_row     (req_press_row),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_channel       (rsp_channel),
      .rsp_column_active (rsp_column_active),
      .rsp_ball_row      (rsp_ball_row),
      .rsp_top_row       (rsp_top_row),
      .rsp_play_note     (rsp_play_note),
      .rsp_last          (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit in case the block hangs.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still owed", cycles,
                  board.outstanding());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Watch register writes and both handshakes at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write) board.write_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall)
            board.apply_request(req_func, req_press_column, req_press_row);
         if (rsp_valid && !rsp_stall)
            board.check_report('{rsp_channel, rsp_column_active, rsp_ball_row,
                                 rsp_top_row, rsp_play_note, rsp_last});
      end
   end

   // Result side stalls in short bursts separated by quiet stretches.
   int stall_left = 0;
   int quiet_left = 0;
   always @(negedge clock) begin
      if (calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (quiet_left != 0) begin
         rsp_stall <= 1'b0;
         quiet_left--;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 6);
         quiet_left = $urandom_range(0, 12);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Sends one request beat, after an optional gap, and waits for acceptance.
   task automatic send(logic func, logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
      int gap;
      gap = (!calm && $urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_func         <= func;
      req_press_column <= col;
      req_press_row    <= row;
      do @(posedge clock); while (req_stall);
      if (func_type'(func) == FUNC_BEAT) beats_sent++;
      else presses_sent++;
   endtask

   task automatic press(int col, int row);
      send(FUNC_PRESS, COL_W'(col), ROW_W'(row));
   endtask

   task automatic tick();
      send(FUNC_BEAT, COL_W'($urandom), ROW_W'($urandom));
   endtask

   // Holds the sender off until every owed report has come and the block
   // has finished writing back any press.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type index, int value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= CFG_W'(value);
      @(posedge clock);
   endtask

   task automatic configure(int channels, int rows);
      drain();
      write_csr(CSR_NUM_CHANNELS, channels);
      write_csr(CSR_NUM_ROWS, rows);
      @(negedge clock);
      csr_write <= 1'b0;
      settings_used++;
   endtask

   // Random traffic: mostly ticks and in-range presses, with presses that
   // stop a column and presses anywhere on the grid mixed in.
   task automatic random_items(int count);
      int kind;
      int col;
      int cols;
      int rows;
      for (int n = 0; n < count; n++) begin
         cols = board.cols_in_use();
         rows = board.rows_in_use();
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            tick();
         end else if (kind < 90 && cols > 0) begin
            col = $urandom_range(0, cols - 1);
            if (kind >= 80 && board.turn_row[col] != ROW_NONE)
               press(col, board.turn_row[col]);
            else
               press(col, $urandom_range(0, rows - 1));
         end else begin
            press($urandom_range(0, 7), $urandom_range(0, 7));
         end
         if ($urandom_range(0, 29) == 0) drain();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset setting: idle tick, extreme rows, stops.
      tick();
      press(0, 0);
      press(7, 7);
      press(3, 4);
      repeat (4) tick();
      press(0, 0);
      press(7, 7);
      tick();

      // Presses outside a reduced grid are ignored.
      configure(4, 5);
      press(5, 1);
      press(1, 6);
      press(3, 4);
      press(2, 1);
      repeat (3) tick();

      // A top row left out of reach once the row count shrinks.
      configure(8, 8);
      press(0, 5);
      tick();
      configure(8, 3);
      repeat (4) tick();

      // Random phases over a spread of settings, the extremes among them.
      configure(1, 2);
      random_items(10);
      configure(8, 2);
      random_items(10);
      configure(1, 8);
      random_items(10);
      configure(0, 3);
      random_items(6);
      configure(15, 15);
      random_items(10);
      configure(3, 0);
      random_items(8);
      configure(5, 1);
      random_items(8);
      repeat (3) begin
         configure($urandom_range(1, 8), $urandom_range(2, 8));
         random_items(10);
      end

      // Last stretch without idling on either side.
      configure(8, 8);
      calm = 1'b1;
      random_items(16);

      drain();
      repeat (20) @(posedge clock);
      if (board.outstanding() != 0) begin
         board.errors++;
         $display("%0t: %0d expected results never arrived", $time,
                  board.outstanding());
      end

      $display("Covered %0d ticks and %0d presses over %0d register settings,",
               beats_sent, presses_sent, settings_used);
      $display("with %0d column reports compared and %0d errors.", board.checked,
               board.errors);
      if (board.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/bns_pkg.sv
design/bns_ram.sv
design/bouncing_note_sequencer_core.sv
verif/tb_top.sv
